@@ rtl/cts_pkg.sv @@
// shared types, constants and saturating fixed-point helpers for the cyclic tridiagonal solver
package cts_pkg;

   localparam int SystemSize = 64;
   localparam int IdxW       = $clog2(SystemSize);
   localparam int CntW       = $clog2(SystemSize + 1);
   localparam int CsrIdxW    = 4;
   localparam int DivBits    = 49;
   localparam int DivCntW    = $clog2(DivBits);

   typedef logic signed [31:0] q_type;
   typedef logic [IdxW-1:0]    idx_type;
   typedef logic [CntW-1:0]    cnt_type;
   typedef logic [CsrIdxW-1:0] csr_idx_type;

   localparam q_type QOne = 32'sd65536;
   localparam q_type QMax = 32'sh7fffffff;
   localparam q_type QMin = 32'sh80000000;

   localparam csr_idx_type RegOffDiagonal = 4'd0;
   localparam csr_idx_type RegDiagonal    = 4'd1;

   localparam q_type ResetOffDiagonal = 32'sd0;
   localparam q_type ResetDiagonal    = 32'sd65536;

   typedef struct packed {
      logic  start;
      q_type op_x;
      q_type op_y;
   } unit_req_type;

   typedef struct packed {
      logic  done;
      q_type value;
   } unit_rsp_type;

   function automatic q_type sat33(logic signed [32:0] s);
      q_type r;
      if (s[32] != s[31]) begin
         r = s[32] ? QMin : QMax;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic q_type sat_add(q_type x, q_type y);
      logic signed [32:0] s;
      s = {x[31], x} + {y[31], y};
      return sat33(s);
   endfunction

   function automatic q_type sat_sub(q_type x, q_type y);
      logic signed [32:0] s;
      s = {x[31], x} - {y[31], y};
      return sat33(s);
   endfunction

   function automatic q_type sat_neg(q_type x);
      return sat_sub(32'sd0, x);
   endfunction

   function automatic logic [31:0] mag32(q_type x);
      logic [31:0] ux;
      ux = x;
      return x[31] ? (~ux + 32'd1) : ux;
   endfunction

   // signed value from sign and magnitude, clamped to the 32-bit range
   function automatic q_type from_mag(logic neg, logic [63:0] m);
      q_type r;
      if (neg) begin
         if (m >= 64'h8000_0000) begin
            r = QMin;
         end else begin
            r = q_type'(~m[31:0] + 32'd1);
         end
      end else begin
         if (m > 64'h7fff_ffff) begin
            r = QMax;
         end else begin
            r = q_type'(m[31:0]);
         end
      end
      return r;
   endfunction

endpackage

@@ rtl/cts_if.sv @@
// valid/ready channel interfaces for rhs input, solution output and register writes
interface cts_req_if;
   logic                 valid;
   logic                 ready;
   cts_pkg::q_type       rhs_value;
   modport source (output valid, output rhs_value, input ready);
   modport sink (input valid, input rhs_value, output ready);
endinterface

interface cts_rsp_if;
   logic                 valid;
   logic                 ready;
   cts_pkg::q_type       solution_value;
   logic                 last_of_run;
   modport source (output valid, output solution_value, output last_of_run, input ready);
   modport sink (input valid, input solution_value, input last_of_run, output ready);
endinterface

interface cts_csr_if;
   logic                 valid;
   logic                 ready;
   cts_pkg::csr_idx_type index;
   cts_pkg::q_type       data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/cts_mul.sv @@
// q16.16 multiplier: registered 64-bit product, then round half away from zero and saturate
module cts_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  cts_pkg::unit_req_type req,
   output cts_pkg::unit_rsp_type rsp
);

   logic signed [63:0] prod_ff;
   logic               vld_ff;
   logic               neg;
   logic [63:0]        mag;
   logic [63:0]        rnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= req.start;
      end
      if (req.start) begin
         prod_ff <= 64'(req.op_x) * 64'(req.op_y);
      end
   end

   always_comb begin
      neg = prod_ff[63];
      mag = neg ? (~prod_ff + 64'd1) : prod_ff;
      rnd = (mag + 64'h8000) >> 16;
   end

   assign rsp.done  = vld_ff;
   assign rsp.value = cts_pkg::from_mag(neg, rnd);

endmodule

@@ rtl/cts_div.sv @@
// q16.16 divider: restoring division, one quotient bit per cycle, rounded and saturated
module cts_div (
   input  logic                  clock,
   input  logic                  reset,
   input  cts_pkg::unit_req_type req,
   output cts_pkg::unit_rsp_type rsp
);

   logic                                busy_ff;
   logic                                done_ff;
   logic                                zero_ff;
   logic                                neg_ff;
   cts_pkg::q_type                      special_ff;
   logic [cts_pkg::DivCntW-1:0]         cnt_ff;
   logic [cts_pkg::DivBits-1:0]         quo_ff;
   logic [32:0]                         rem_ff;
   logic [31:0]                         dv_ff;
   logic [32:0]                         rem_sh;
   logic                                fits;
   logic [31:0]                         mag_n;
   logic [31:0]                         mag_d;

   always_comb begin
      mag_n  = cts_pkg::mag32(req.op_x);
      mag_d  = cts_pkg::mag32(req.op_y);
      rem_sh = {rem_ff[31:0], quo_ff[cts_pkg::DivBits-1]};
      fits   = rem_sh >= {1'b0, dv_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            if (req.op_y == 32'sd0) begin
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end else if (busy_ff && cnt_ff == cts_pkg::DivCntW'(cts_pkg::DivBits - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (req.start) begin
         zero_ff <= req.op_y == 32'sd0;
         neg_ff  <= req.op_x[31] != req.op_y[31];
         if (req.op_x > 32'sd0) begin
            special_ff <= cts_pkg::QMax;
         end else if (req.op_x < 32'sd0) begin
            special_ff <= cts_pkg::QMin;
         end else begin
            special_ff <= 32'sd0;
         end
         cnt_ff <= '0;
         rem_ff <= '0;
         dv_ff  <= mag_d;
         // rounding offset of half the divisor folded into the dividend
         quo_ff <= {1'b0, mag_n, 16'h0000} + cts_pkg::DivBits'(mag_d >> 1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= fits ? (rem_sh - {1'b0, dv_ff}) : rem_sh;
         quo_ff <= {quo_ff[cts_pkg::DivBits-2:0], fits};
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = zero_ff ? special_ff
                              : cts_pkg::from_mag(neg_ff, 64'(quo_ff));

endmodule

@@ rtl/cyclic_tridiagonal_solver_unit.sv @@
// top level: rhs load, vector stores and sequencer for the periodic tridiagonal solve
//
// req_ch takes one rhs_value per transaction; the first transaction after reset or after
// a finished run is element 0. Once element SystemSize-1 is taken the block drops
// req_ch.ready and solves: a forward sweep, the corner row, a backward sweep, the
// Sherman-Morrison factor and a final correction pass. All multiplications and divisions
// go through one multiplier and one restoring divider, so the divider sets the pace:
// the forward sweep divides once per element, the backward sweep uses the multiplier
// alone, and 8 further divisions serve setup, corner row and correction. rsp_ch then
// delivers solution_value in index order, last_of_run high on the final element. Each
// result sits in an output register until the receiver takes it; a stall simply holds
// the sequencer, nothing is lost. req_ch reopens after the final result.
// csr_ch is always ready: index 0 writes off_diagonal, index 1 writes diagonal, other
// indexes are ignored. Write registers only while no system is being solved.
// reset (synchronous) sets off_diagonal to 0, diagonal to 1.0 and the load count to 0;
// the vector stores are not cleared, every entry is written before it is read.
module cyclic_tridiagonal_solver_unit (
   input logic        clock,
   input logic        reset,
   cts_req_if.sink    req_ch,
   cts_rsp_if.source  rsp_ch,
   cts_csr_if.sink    csr_ch
);

   localparam int N = cts_pkg::SystemSize;

   typedef enum logic [33:0] {
      S_IDLE    = 34'b1 << 0,
      S_INIT    = 34'b1 << 1,
      S_D0      = 34'b1 << 2,
      S_C0      = 34'b1 << 3,
      S_U0      = 34'b1 << 4,
      S_X0      = 34'b1 << 5,
      S_F_FETCH = 34'b1 << 6,
      S_F_M1    = 34'b1 << 7,
      S_F_DIV   = 34'b1 << 8,
      S_F_C     = 34'b1 << 9,
      S_F_U1    = 34'b1 << 10,
      S_F_U2    = 34'b1 << 11,
      S_F_X1    = 34'b1 << 12,
      S_F_X2    = 34'b1 << 13,
      S_L_FETCH = 34'b1 << 14,
      S_L_M1    = 34'b1 << 15,
      S_L_D1    = 34'b1 << 16,
      S_L_M2    = 34'b1 << 17,
      S_L_DIV   = 34'b1 << 18,
      S_L_U1    = 34'b1 << 19,
      S_L_U2    = 34'b1 << 20,
      S_L_X1    = 34'b1 << 21,
      S_L_X2    = 34'b1 << 22,
      S_B_FETCH = 34'b1 << 23,
      S_B_U     = 34'b1 << 24,
      S_B_X     = 34'b1 << 25,
      S_C_M1    = 34'b1 << 26,
      S_C_D1    = 34'b1 << 27,
      S_C_M2    = 34'b1 << 28,
      S_C_D2    = 34'b1 << 29,
      S_C_DIV   = 34'b1 << 30,
      S_O_FETCH = 34'b1 << 31,
      S_O_M     = 34'b1 << 32,
      S_O_SEND  = 34'b1 << 33
   } state_type;

   state_type             state_ff, state_in;
   logic                  issued_ff, issued_in;
   cts_pkg::cnt_type      load_cnt_ff;
   cts_pkg::idx_type      idx_ff;
   cts_pkg::q_type        off_diag_ff, diag_ff;
   cts_pkg::q_type        g_ff, d0_ff, t_ff, t2_ff, m_ff;
   cts_pkg::q_type        cprev_ff, uprev_ff, xprev_ff, ulast_ff, xlast_ff;
   cts_pkg::q_type        num_ff, fact_ff;
   cts_pkg::q_type        xr_ff, cr_ff, ur_ff;
   cts_pkg::q_type        rsp_value_ff;
   logic                  rsp_last_ff, rsp_valid_ff;

   cts_pkg::q_type        x_mem [N];
   cts_pkg::q_type        c_mem [N];
   cts_pkg::q_type        u_mem [N];

   cts_pkg::unit_req_type mul_req, div_req;
   cts_pkg::unit_rsp_type mul_rsp, div_rsp;
   logic                  use_mul, use_div, unit_done;
   cts_pkg::q_type        op_x, op_y;
   logic                  x_we, c_we, u_we;
   cts_pkg::q_type        x_wd, c_wd, u_wd;
   logic                  load_accept;
   logic                  idx_last;

   cts_mul u_mul (.clock(clock), .reset(reset), .req(mul_req), .rsp(mul_rsp));
   cts_div u_div (.clock(clock), .reset(reset), .req(div_req), .rsp(div_rsp));

   assign load_accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = state_ff == S_IDLE;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.solution_value = rsp_value_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;
   assign unit_done = mul_rsp.done || div_rsp.done;
   assign idx_last = idx_ff == cts_pkg::idx_type'(N - 1);

   // operand selection for the shared units
   always_comb begin
      use_mul = 1'b0;
      use_div = 1'b0;
      op_x    = '0;
      op_y    = '0;
      unique case (state_ff)
         S_C0:    begin use_div = 1'b1; op_x = off_diag_ff; op_y = d0_ff; end
         S_U0:    begin use_div = 1'b1; op_x = g_ff; op_y = d0_ff; end
         S_X0:    begin use_div = 1'b1; op_x = xr_ff; op_y = d0_ff; end
         S_F_M1:  begin use_mul = 1'b1; op_x = off_diag_ff; op_y = cprev_ff; end
         S_F_DIV: begin
            use_div = 1'b1; op_x = cts_pkg::QOne; op_y = cts_pkg::sat_sub(diag_ff, t_ff);
         end
         S_F_C:   begin use_mul = 1'b1; op_x = off_diag_ff; op_y = m_ff; end
         S_F_U1:  begin use_mul = 1'b1; op_x = off_diag_ff; op_y = uprev_ff; end
         S_F_U2:  begin use_mul = 1'b1; op_x = cts_pkg::sat_neg(t_ff); op_y = m_ff; end
         S_F_X1:  begin use_mul = 1'b1; op_x = off_diag_ff; op_y = xprev_ff; end
         S_F_X2:  begin use_mul = 1'b1; op_x = cts_pkg::sat_sub(xr_ff, t_ff); op_y = m_ff; end
         S_L_M1:  begin use_mul = 1'b1; op_x = off_diag_ff; op_y = off_diag_ff; end
         S_L_D1:  begin use_div = 1'b1; op_x = t_ff; op_y = g_ff; end
         S_L_M2:  begin use_mul = 1'b1; op_x = off_diag_ff; op_y = cprev_ff; end
         S_L_DIV: begin
            use_div = 1'b1;
            op_x = cts_pkg::QOne;
            op_y = cts_pkg::sat_sub(cts_pkg::sat_sub(diag_ff, t2_ff), t_ff);
         end
         S_L_U1:  begin use_mul = 1'b1; op_x = off_diag_ff; op_y = uprev_ff; end
         S_L_U2:  begin
            use_mul = 1'b1; op_x = cts_pkg::sat_sub(off_diag_ff, t_ff); op_y = m_ff;
         end
         S_L_X1:  begin use_mul = 1'b1; op_x = off_diag_ff; op_y = xprev_ff; end
         S_L_X2:  begin use_mul = 1'b1; op_x = cts_pkg::sat_sub(xr_ff, t_ff); op_y = m_ff; end
         S_B_U:   begin use_mul = 1'b1; op_x = cr_ff; op_y = uprev_ff; end
         S_B_X:   begin use_mul = 1'b1; op_x = cr_ff; op_y = xprev_ff; end
         S_C_M1:  begin use_mul = 1'b1; op_x = xlast_ff; op_y = off_diag_ff; end
         S_C_D1:  begin use_div = 1'b1; op_x = t_ff; op_y = g_ff; end
         S_C_M2:  begin use_mul = 1'b1; op_x = ulast_ff; op_y = off_diag_ff; end
         S_C_D2:  begin use_div = 1'b1; op_x = t_ff; op_y = g_ff; end
         S_C_DIV: begin use_div = 1'b1; op_x = num_ff; op_y = t2_ff; end
         S_O_M:   begin use_mul = 1'b1; op_x = fact_ff; op_y = ur_ff; end
         default: begin end
      endcase
      mul_req.start = use_mul && !issued_ff;
      mul_req.op_x  = op_x;
      mul_req.op_y  = op_y;
      div_req.start = use_div && !issued_ff;
      div_req.op_x  = op_x;
      div_req.op_y  = op_y;
      issued_in = issued_ff ? !unit_done : (use_mul || use_div);
   end

   // store writes from the sequencer
   always_comb begin
      x_we = 1'b0;
      c_we = 1'b0;
      u_we = 1'b0;
      x_wd = mul_rsp.value;
      c_wd = mul_rsp.value;
      u_wd = mul_rsp.value;
      unique case (state_ff)
         S_C0:   begin c_we = unit_done; c_wd = div_rsp.value; end
         S_F_C:  c_we = unit_done;
         S_U0:   begin u_we = unit_done; u_wd = div_rsp.value; end
         S_F_U2, S_L_U2: u_we = unit_done;
         S_B_U:  begin u_we = unit_done; u_wd = cts_pkg::sat_sub(ur_ff, mul_rsp.value); end
         S_X0:   begin x_we = unit_done; x_wd = div_rsp.value; end
         S_F_X2, S_L_X2: x_we = unit_done;
         S_B_X:  begin x_we = unit_done; x_wd = cts_pkg::sat_sub(xr_ff, mul_rsp.value); end
         default: begin end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_accept) begin
         x_mem[load_cnt_ff[cts_pkg::IdxW-1:0]] <= req_ch.rhs_value;
      end else if (x_we) begin
         x_mem[idx_ff] <= x_wd;
      end
      if (c_we) begin
         c_mem[idx_ff] <= c_wd;
      end
      if (u_we) begin
         u_mem[idx_ff] <= u_wd;
      end
      xr_ff <= x_mem[idx_ff];
      cr_ff <= c_mem[idx_ff];
      ur_ff <= u_mem[idx_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (load_accept && load_cnt_ff == cts_pkg::cnt_type'(N - 1)) begin
            state_in = S_INIT;
         end
         S_INIT:    state_in = S_D0;
         S_D0:      state_in = S_C0;
         S_C0:      if (unit_done) state_in = S_U0;
         S_U0:      if (unit_done) state_in = S_X0;
         S_X0:      if (unit_done) state_in = S_F_FETCH;
         S_F_FETCH: state_in = S_F_M1;
         S_F_M1:    if (unit_done) state_in = S_F_DIV;
         S_F_DIV:   if (unit_done) state_in = S_F_C;
         S_F_C:     if (unit_done) state_in = S_F_U1;
         S_F_U1:    if (unit_done) state_in = S_F_U2;
         S_F_U2:    if (unit_done) state_in = S_F_X1;
         S_F_X1:    if (unit_done) state_in = S_F_X2;
         S_F_X2:    if (unit_done) begin
            state_in = (idx_ff == cts_pkg::idx_type'(N - 2)) ? S_L_FETCH : S_F_FETCH;
         end
         S_L_FETCH: state_in = S_L_M1;
         S_L_M1:    if (unit_done) state_in = S_L_D1;
         S_L_D1:    if (unit_done) state_in = S_L_M2;
         S_L_M2:    if (unit_done) state_in = S_L_DIV;
         S_L_DIV:   if (unit_done) state_in = S_L_U1;
         S_L_U1:    if (unit_done) state_in = S_L_U2;
         S_L_U2:    if (unit_done) state_in = S_L_X1;
         S_L_X1:    if (unit_done) state_in = S_L_X2;
         S_L_X2:    if (unit_done) state_in = S_B_FETCH;
         S_B_FETCH: state_in = S_B_U;
         S_B_U:     if (unit_done) state_in = S_B_X;
         S_B_X:     if (unit_done) state_in = (idx_ff == '0) ? S_C_M1 : S_B_FETCH;
         S_C_M1:    if (unit_done) state_in = S_C_D1;
         S_C_D1:    if (unit_done) state_in = S_C_M2;
         S_C_M2:    if (unit_done) state_in = S_C_D2;
         S_C_D2:    if (unit_done) state_in = S_C_DIV;
         S_C_DIV:   if (unit_done) state_in = S_O_FETCH;
         S_O_FETCH: state_in = S_O_M;
         S_O_M:     if (unit_done) state_in = S_O_SEND;
         S_O_SEND:  if (rsp_ch.ready) state_in = rsp_last_ff ? S_IDLE : S_O_FETCH;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         load_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         off_diag_ff  <= cts_pkg::ResetOffDiagonal;
         diag_ff      <= cts_pkg::ResetDiagonal;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         if (load_accept) begin
            load_cnt_ff <= (load_cnt_ff == cts_pkg::cnt_type'(N - 1)) ? '0
                                                                     : load_cnt_ff + 1'b1;
         end
         if (state_ff == S_O_M && unit_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            unique case (csr_ch.index)
               cts_pkg::RegOffDiagonal: off_diag_ff <= csr_ch.data;
               cts_pkg::RegDiagonal:    diag_ff <= csr_ch.data;
               default: begin end
            endcase
         end
      end
   end

   // datapath registers of the sequencer
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_INIT: begin
            g_ff   <= cts_pkg::sat_neg(diag_ff);
            idx_ff <= '0;
         end
         S_D0: d0_ff <= cts_pkg::sat_sub(diag_ff, g_ff);
         S_C0: if (unit_done) cprev_ff <= div_rsp.value;
         S_U0: if (unit_done) uprev_ff <= div_rsp.value;
         S_X0: if (unit_done) begin
            xprev_ff <= div_rsp.value;
            idx_ff   <= cts_pkg::idx_type'(1);
         end
         S_F_M1, S_F_U1, S_F_X1, S_L_M2, S_L_U1, S_L_X1, S_C_M1, S_C_M2:
            if (unit_done) t_ff <= mul_rsp.value;
         S_F_DIV, S_L_DIV: if (unit_done) m_ff <= div_rsp.value;
         S_F_C:  if (unit_done) cprev_ff <= mul_rsp.value;
         S_F_U2: if (unit_done) uprev_ff <= mul_rsp.value;
         S_F_X2: if (unit_done) begin
            xprev_ff <= mul_rsp.value;
            idx_ff   <= idx_ff + 1'b1;
         end
         S_L_M1: if (unit_done) t_ff <= mul_rsp.value;
         S_L_D1: if (unit_done) t2_ff <= div_rsp.value;
         S_L_U2: if (unit_done) begin
            uprev_ff <= mul_rsp.value;
            ulast_ff <= mul_rsp.value;
         end
         S_L_X2: if (unit_done) begin
            xprev_ff <= mul_rsp.value;
            xlast_ff <= mul_rsp.value;
            idx_ff   <= cts_pkg::idx_type'(N - 2);
         end
         S_B_U: if (unit_done) uprev_ff <= u_wd;
         S_B_X: if (unit_done) begin
            xprev_ff <= x_wd;
            if (idx_ff != '0) begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
         S_C_D1: if (unit_done) num_ff <= cts_pkg::sat_add(xprev_ff, div_rsp.value);
         S_C_D2: if (unit_done) begin
            t2_ff <= cts_pkg::sat_add(cts_pkg::sat_add(cts_pkg::QOne, uprev_ff),
                                      div_rsp.value);
         end
         S_C_DIV: if (unit_done) begin
            fact_ff <= div_rsp.value;
            idx_ff  <= '0;
         end
         S_O_M: if (unit_done) begin
            rsp_value_ff <= cts_pkg::sat_sub(xr_ff, mul_rsp.value);
            rsp_last_ff  <= idx_last;
         end
         S_O_SEND: if (rsp_ch.ready && !rsp_last_ff) idx_ff <= idx_ff + 1'b1;
         default: begin end
      endcase
   end

   // no new rhs while a solution element is pending
   a_no_load_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("rhs accepted while a result is pending");

   a_solve_starts: assert property (@(posedge clock) disable iff (reset)
      (load_accept && load_cnt_ff == cts_pkg::cnt_type'(N - 1)) |=> state_ff == S_INIT)
      else $error("solve did not start after the final rhs element");

   a_done_when_issued: assert property (@(posedge clock) disable iff (reset)
      (mul_rsp.done || div_rsp.done) |-> issued_ff)
      else $error("unit result without an issued operation");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({mul_req.start, div_req.start}))
      else $error("both arithmetic units started together");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_cnt_ff < cts_pkg::cnt_type'(N))
      else $error("load count beyond system size");

endmodule
